@@ src/ibqdp_pkg.sv @@
// Shared constants and types for the INT4 block-quantized dot product.
package ibqdp_pkg;

    localparam int LEN_W     = 13;
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 16;
    localparam int NIB_W     = 4;
    localparam int NIB_SHIFT = 4;
    localparam int W_W       = NIB_W + 1;
    localparam int PROD_W    = 2 * ACT_W;
    localparam int TERM_W    = PROD_W + W_W;
    localparam int SUM_W     = 47;

    localparam logic [NIB_W-1:0]      NIB_MASK = 4'hF;
    localparam logic signed [W_W-1:0] NIB_BIAS = 5'sd8;

    localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 13'd4096;

    localparam int DEF_BLOCK_SIZE = 32;
    localparam int DEF_MAX_ROW    = 4096;

    typedef struct packed {
        logic signed [W_W-1:0]   w;
        logic signed [ACT_W-1:0] act;
        logic signed [ACT_W-1:0] scale;
    } t_lane_in;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

@@ src/ibqdp_front.sv @@
// Input stage: row position, block scale tracking and lane operand setup.
module ibqdp_front #(
    parameter int BLOCK_SIZE = ibqdp_pkg::DEF_BLOCK_SIZE,
    parameter int MAX_ROW    = ibqdp_pkg::DEF_MAX_ROW
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  logic                                  i_in_valid,
    input  logic        [ibqdp_pkg::BYTE_W-1:0]   i_weight_byte,
    input  logic signed [ibqdp_pkg::ACT_W-1:0]    i_act_even,
    input  logic signed [ibqdp_pkg::ACT_W-1:0]    i_act_odd,
    input  logic signed [ibqdp_pkg::ACT_W-1:0]    i_block_scale,
    input  logic        [ibqdp_pkg::LEN_W-1:0]    i_row_length,
    output ibqdp_pkg::t_ctl                       o_ctl,
    output ibqdp_pkg::t_lane_in                   o_even,
    output ibqdp_pkg::t_lane_in                   o_odd
);

    localparam int OFF_W = $clog2(BLOCK_SIZE + 2);
    localparam logic [OFF_W-1:0] BLK      = OFF_W'(BLOCK_SIZE);
    localparam logic [OFF_W-1:0] BLK_LAST = OFF_W'(BLOCK_SIZE - 1);
    localparam logic [OFF_W-1:0] OFF_STEP = OFF_W'(2);

    logic                                  accept;
    logic        [ibqdp_pkg::LEN_W-1:0]    len;
    logic        [ibqdp_pkg::LEN_W:0]      pos1;
    logic        [ibqdp_pkg::LEN_W:0]      pos2;
    logic                                  odd_counts;
    logic                                  row_done;
    logic signed [ibqdp_pkg::ACT_W-1:0]    s_even;
    logic signed [ibqdp_pkg::ACT_W-1:0]    s_odd;
    logic        [OFF_W-1:0]               off_sum;
    logic        [ibqdp_pkg::BYTE_W-1:0]   hi_byte;
    logic signed [ibqdp_pkg::W_W-1:0]      w_even;
    logic signed [ibqdp_pkg::W_W-1:0]      w_odd;

    logic        [ibqdp_pkg::LEN_W-1:0]    r_pos;
    logic        [ibqdp_pkg::LEN_W-1:0]    n_pos;
    logic        [OFF_W-1:0]               r_off;
    logic        [OFF_W-1:0]               n_off;
    logic signed [ibqdp_pkg::ACT_W-1:0]    r_held_scale;
    logic signed [ibqdp_pkg::ACT_W-1:0]    n_held_scale;
    ibqdp_pkg::t_ctl                       r_ctl;
    ibqdp_pkg::t_lane_in                   r_even;
    ibqdp_pkg::t_lane_in                   r_odd;

    assign accept = i_in_valid & i_advance;

    always_comb begin
        priority if (i_row_length == '0) begin
            len = ibqdp_pkg::LEN_W'(1);
        end else if (i_row_length > ibqdp_pkg::LEN_W'(MAX_ROW)) begin
            len = ibqdp_pkg::LEN_W'(MAX_ROW);
        end else begin
            len = i_row_length;
        end
    end

    assign pos1       = {1'b0, r_pos} + (ibqdp_pkg::LEN_W + 1)'(1);
    assign pos2       = {1'b0, r_pos} + (ibqdp_pkg::LEN_W + 1)'(2);
    assign odd_counts = pos1 < {1'b0, len};
    assign row_done   = pos2 >= {1'b0, len};

    assign s_even = (r_off == '0) ? i_block_scale : r_held_scale;
    assign s_odd  = (r_off == BLK_LAST) ? i_block_scale : s_even;

    assign hi_byte = i_weight_byte >> ibqdp_pkg::NIB_SHIFT;
    assign w_even  = $signed({1'b0, i_weight_byte[ibqdp_pkg::NIB_W-1:0] & ibqdp_pkg::NIB_MASK})
                     - ibqdp_pkg::NIB_BIAS;
    assign w_odd   = $signed({1'b0, hi_byte[ibqdp_pkg::NIB_W-1:0] & ibqdp_pkg::NIB_MASK})
                     - ibqdp_pkg::NIB_BIAS;

    assign off_sum = r_off + OFF_STEP;

    always_comb begin
        n_pos        = r_pos;
        n_off        = r_off;
        n_held_scale = r_held_scale;
        if (accept) begin
            n_held_scale = odd_counts ? s_odd : s_even;
            if (row_done) begin
                n_pos = '0;
                n_off = '0;
            end else begin
                n_pos = pos2[ibqdp_pkg::LEN_W-1:0];
                n_off = (off_sum >= BLK) ? off_sum - BLK : off_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_off        <= '0;
            r_held_scale <= '0;
            r_ctl        <= '0;
        end else begin
            r_pos        <= n_pos;
            r_off        <= n_off;
            r_held_scale <= n_held_scale;
            if (i_advance) begin
                r_ctl.valid <= accept;
                r_ctl.last  <= row_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_even.w     <= w_even;
            r_even.act   <= i_act_even;
            r_even.scale <= s_even;
            r_odd.w      <= odd_counts ? w_odd : '0;
            r_odd.act    <= i_act_odd;
            r_odd.scale  <= s_odd;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_even = r_even;
    assign o_odd  = r_odd;

endmodule

@@ src/ibqdp_lane.sv @@
// One multiply lane: activation times scale, then times the signed nibble.
module ibqdp_lane (
    input  logic                                 i_clk,
    input  logic                                 i_advance,
    input  ibqdp_pkg::t_lane_in                  i_lane,
    output logic signed [ibqdp_pkg::TERM_W-1:0]  o_term
);

    logic signed [ibqdp_pkg::PROD_W-1:0] prod;
    logic signed [ibqdp_pkg::W_W-1:0]    r_w;
    logic signed [ibqdp_pkg::PROD_W-1:0] r_prod;
    logic signed [ibqdp_pkg::TERM_W-1:0] r_term;

    assign prod = i_lane.act * i_lane.scale;

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_w    <= i_lane.w;
            r_prod <= prod;
            r_term <= r_w * r_prod;
        end
    end

    assign o_term = r_term;

endmodule

@@ src/ibqdp_merge.sv @@
// Merge stage: sum both lane terms into the row accumulator and hold the result.
module ibqdp_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ibqdp_pkg::t_ctl                      i_ctl,
    input  logic signed [ibqdp_pkg::TERM_W-1:0]  i_term_even,
    input  logic signed [ibqdp_pkg::TERM_W-1:0]  i_term_odd,
    input  logic                                 i_out_stall,
    output logic                                 o_advance,
    output logic                                 o_out_valid,
    output logic signed [ibqdp_pkg::SUM_W-1:0]   o_dot_value
);

    logic                                hold;
    logic                                emit;
    logic signed [ibqdp_pkg::SUM_W-1:0]  total;
    logic signed [ibqdp_pkg::SUM_W-1:0]  r_sum;
    logic signed [ibqdp_pkg::SUM_W-1:0]  n_sum;
    logic                                r_out_valid;
    logic                                n_out_valid;
    logic signed [ibqdp_pkg::SUM_W-1:0]  r_dot;

    assign hold  = r_out_valid & i_out_stall & i_ctl.valid & i_ctl.last;
    assign emit  = i_ctl.valid & i_ctl.last & ~hold;
    assign total = r_sum + ibqdp_pkg::SUM_W'(i_term_even) + ibqdp_pkg::SUM_W'(i_term_odd);

    always_comb begin
        n_sum       = r_sum;
        n_out_valid = r_out_valid & i_out_stall;
        if (i_ctl.valid && !hold) begin
            n_sum = i_ctl.last ? '0 : total;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_dot <= total;
        end
    end

    assign o_advance   = ~hold;
    assign o_out_valid = r_out_valid;
    assign o_dot_value = r_dot;

endmodule

@@ src/int4_block_quant_dot_product.sv @@
// Top level of the INT4 block-quantized dot product.
//
// Input channel (i_in_valid / o_in_stall): one transaction per packed weight
// byte with its even and odd activations and the scale of the current block.
// The scale is sampled on the element that starts a block. Output channel
// (o_out_valid / i_out_stall): one transaction per finished row, carrying the
// exact 47-bit dot product. Configuration channel (i_cfg_valid / o_cfg_ready)
// writes the row length; write it only while no row is in flight.
// Throughput: one input transaction per cycle while o_in_stall is low.
// Each item passes an input stage, two multiply stages in each of the even
// and odd lanes, and one accumulator add, and the row's result is then
// registered onto o_out_valid.
// When the receiver stalls, the finished result waits in the output register
// and the pipeline keeps accepting; o_in_stall rises only when the next row's
// last item reaches the accumulator while that result is still not taken.
// Reset (synchronous, active low) clears the row position, held scale,
// accumulator and all valid flags, and sets the row length to 4096.
module int4_block_quant_dot_product #(
    parameter int BLOCK_SIZE = ibqdp_pkg::DEF_BLOCK_SIZE,
    parameter int MAX_ROW    = ibqdp_pkg::DEF_MAX_ROW
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic        [ibqdp_pkg::BYTE_W-1:0]  i_weight_byte,
    input  logic signed [ibqdp_pkg::ACT_W-1:0]   i_act_even,
    input  logic signed [ibqdp_pkg::ACT_W-1:0]   i_act_odd,
    input  logic signed [ibqdp_pkg::ACT_W-1:0]   i_block_scale,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [ibqdp_pkg::SUM_W-1:0]   o_dot_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [ibqdp_pkg::LEN_W-1:0]   i_cfg_data
);

    logic                                 advance;
    logic        [ibqdp_pkg::LEN_W-1:0]   r_row_length;
    ibqdp_pkg::t_ctl                      ctl0;
    ibqdp_pkg::t_ctl                      r_ctl1;
    ibqdp_pkg::t_ctl                      r_ctl2;
    ibqdp_pkg::t_lane_in                  lane_even;
    ibqdp_pkg::t_lane_in                  lane_odd;
    logic signed [ibqdp_pkg::TERM_W-1:0]  term_even;
    logic signed [ibqdp_pkg::TERM_W-1:0]  term_odd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = ~advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= ibqdp_pkg::ROW_LENGTH_RESET;
            r_ctl1       <= '0;
            r_ctl2       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_row_length <= i_cfg_data;
            end
            if (advance) begin
                r_ctl1 <= ctl0;
                r_ctl2 <= r_ctl1;
            end
        end
    end

    ibqdp_front #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .MAX_ROW    (MAX_ROW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_in_valid    (i_in_valid),
        .i_weight_byte (i_weight_byte),
        .i_act_even    (i_act_even),
        .i_act_odd     (i_act_odd),
        .i_block_scale (i_block_scale),
        .i_row_length  (r_row_length),
        .o_ctl         (ctl0),
        .o_even        (lane_even),
        .o_odd         (lane_odd)
    );

    ibqdp_lane u_lane_even (
        .i_clk     (i_clk),
        .i_advance (advance),
        .i_lane    (lane_even),
        .o_term    (term_even)
    );

    ibqdp_lane u_lane_odd (
        .i_clk     (i_clk),
        .i_advance (advance),
        .i_lane    (lane_odd),
        .o_term    (term_odd)
    );

    ibqdp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl2),
        .i_term_even (term_even),
        .i_term_odd  (term_odd),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_dot_value (o_dot_value)
    );

endmodule
